// ===== sv/lqgm_pkg.sv =====
`default_nettype none

package lqgm_pkg;

    // Field widths of the input and result items.
    localparam int RNG_W    = 16;
    localparam int IDX_IN_W = 11;
    localparam int OUT_W    = 17;

    // Trig table format: Q15 magnitudes for whole degrees 0..90.
    localparam int TRIG_W    = 16;
    localparam int SIN_IDX_W = 7;
    localparam int ANG_W     = 9;

    // Product, sum and rounding of the midpoint arithmetic.
    localparam int PROD_W  = RNG_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_SH = 16;

    typedef logic [RNG_W-1:0]         t_range;
    typedef logic [TRIG_W-1:0]        t_trig;
    typedef logic [ANG_W-1:0]         t_angle;
    typedef logic [PROD_W-1:0]        t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [OUT_W-1:0]  t_coord;

    localparam t_range NO_RETURN = 16'hFFFF;
    localparam logic [OUT_W-1:0] OUT_MAX    = 17'd65535;
    localparam logic [SUM_W-1:0] ROUND_HALF = 33'd32768;

    // Angle constants in degrees.
    localparam int DEG_FULL    = 360;
    localparam int DEG_HALF    = 180;
    localparam int DEG_QUARTER = 90;

    // Sector codes.
    localparam logic [1:0] SEC0 = 2'd0;
    localparam logic [1:0] SEC1 = 2'd1;
    localparam logic [1:0] SEC2 = 2'd2;
    localparam logic [1:0] SEC3 = 2'd3;

    // Pair codes: pair A is sectors 0 and 2, pair B is sectors 3 and 1.
    localparam logic PAIR_A = 1'b0;
    localparam logic PAIR_B = 1'b1;

    // Quadrant signs, one bit per sector, set where the coordinate is negative.
    localparam logic [3:0] NEG_X = 4'b0011;
    localparam logic [3:0] NEG_Y = 4'b0110;

    // round(32768 * sin(d)) for d = 0..90.
    localparam t_trig SIN_Q15 [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

endpackage

`default_nettype wire

// ===== sv/lqgm_sector.sv =====
`default_nettype none

module lqgm_sector
    import lqgm_pkg::*;
#(
    parameter int SECTOR_SAMPLES = 360,
    localparam int LW = $clog2(SECTOR_SAMPLES),
    localparam int GW = $clog2(4 * SECTOR_SAMPLES)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_range              i_range_mm,
    input  wire logic [IDX_IN_W-1:0] i_sample_index,
    input  wire logic                i_end_of_scan,
    output logic                     o_ev_valid,
    input  wire logic                i_ev_ready,
    output t_range                   o_rng_a,
    output t_range                   o_rng_b,
    output logic [GW-1:0]            o_glb_a,
    output logic [GW-1:0]            o_glb_b,
    output logic                     o_pair
);

    localparam int CW = ($clog2(4 * SECTOR_SAMPLES + 1) > IDX_IN_W) ?
                        $clog2(4 * SECTOR_SAMPLES + 1) : IDX_IN_W;

    logic                r_in_v;
    t_range              r_in_rng;
    logic [IDX_IN_W-1:0] r_in_idx;
    logic                r_in_last;

    t_range              r_min_rng [4];
    logic [LW-1:0]       r_min_idx [4];
    t_range              n_min_rng [4];
    logic [LW-1:0]       n_min_idx [4];

    logic                r_ev_v;
    t_range              r_rng_a;
    t_range              r_rng_b;
    logic [GW-1:0]       r_glb_a;
    logic [GW-1:0]       r_glb_b;
    logic                r_pair;

    logic [CW-1:0]       idx_e;
    logic [CW-1:0]       base;
    logic [1:0]          sec;
    logic                hit;
    logic [LW-1:0]       local_idx;
    logic                emit_ok;
    logic                pair;
    logic                eval_emit;
    logic                ev_ready;
    logic                consume;
    t_range              n_rng_a;
    t_range              n_rng_b;
    logic [GW-1:0]       n_glb_a;
    logic [GW-1:0]       n_glb_b;

    // Sector of the held sample and its index within the sector.
    always_comb begin
        idx_e = CW'(r_in_idx);
        hit   = idx_e < CW'(4 * SECTOR_SAMPLES);
        priority if (idx_e < CW'(SECTOR_SAMPLES)) begin
            sec = SEC0;
        end else if (idx_e < CW'(2 * SECTOR_SAMPLES)) begin
            sec = SEC1;
        end else if (idx_e < CW'(3 * SECTOR_SAMPLES)) begin
            sec = SEC2;
        end else begin
            sec = SEC3;
        end
        unique case (sec)
            SEC0:    base = '0;
            SEC1:    base = CW'(SECTOR_SAMPLES);
            SEC2:    base = CW'(2 * SECTOR_SAMPLES);
            default: base = CW'(3 * SECTOR_SAMPLES);
        endcase
        local_idx = LW'(idx_e - base);
    end

    // Running minima with the held sample merged in; on a tie the lower index wins.
    always_comb begin
        for (int s = 0; s < 4; s++) begin
            n_min_rng[s] = r_min_rng[s];
            n_min_idx[s] = r_min_idx[s];
            if (hit && sec == 2'(s) &&
                (r_in_rng < r_min_rng[s] ||
                 (r_in_rng == r_min_rng[s] && local_idx < r_min_idx[s]))) begin
                n_min_rng[s] = r_in_rng;
                n_min_idx[s] = local_idx;
            end
        end
    end

    // Pair choice at the end of a scan; with returns in sectors 1 and 2, equal sector 0 and 3 minima give no result.
    always_comb begin
        emit_ok = 1'b1;
        pair    = PAIR_A;
        priority if (n_min_rng[1] == NO_RETURN) begin
            pair = PAIR_A;
        end else if (n_min_rng[2] == NO_RETURN) begin
            pair = PAIR_B;
        end else if (n_min_rng[0] < n_min_rng[3]) begin
            pair = PAIR_A;
        end else if (n_min_rng[0] > n_min_rng[3]) begin
            pair = PAIR_B;
        end else begin
            emit_ok = 1'b0;
        end
    end

    // Scan positions and ranges of the two chosen sector minima.
    always_comb begin
        if (pair == PAIR_B) begin
            n_rng_a = n_min_rng[3];
            n_rng_b = n_min_rng[1];
            n_glb_a = GW'(3 * SECTOR_SAMPLES) + GW'(n_min_idx[3]);
            n_glb_b = GW'(SECTOR_SAMPLES) + GW'(n_min_idx[1]);
        end else begin
            n_rng_a = n_min_rng[0];
            n_rng_b = n_min_rng[2];
            n_glb_a = GW'(n_min_idx[0]);
            n_glb_b = GW'(2 * SECTOR_SAMPLES) + GW'(n_min_idx[2]);
        end
    end

    // Handshake: an item leaves the input register unless its result cannot move on.
    assign eval_emit = r_in_last && emit_ok;
    assign ev_ready  = !r_ev_v || i_ev_ready;
    assign consume   = r_in_v && (!eval_emit || ev_ready);
    assign o_ready   = !r_in_v || consume;

    // Control state and the sector minima.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_ev_v <= 1'b0;
            for (int s = 0; s < 4; s++) begin
                r_min_rng[s] <= NO_RETURN;
                r_min_idx[s] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_in_v <= i_valid;
            end
            if (ev_ready) begin
                r_ev_v <= consume && eval_emit;
            end
            if (consume) begin
                for (int s = 0; s < 4; s++) begin
                    if (r_in_last) begin
                        r_min_rng[s] <= NO_RETURN;
                        r_min_idx[s] <= '0;
                    end else begin
                        r_min_rng[s] <= n_min_rng[s];
                        r_min_idx[s] <= n_min_idx[s];
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_rng  <= i_range_mm;
            r_in_idx  <= i_sample_index;
            r_in_last <= i_end_of_scan;
        end
        if (ev_ready && consume && eval_emit) begin
            r_rng_a <= n_rng_a;
            r_rng_b <= n_rng_b;
            r_glb_a <= n_glb_a;
            r_glb_b <= n_glb_b;
            r_pair  <= pair;
        end
    end

    assign o_ev_valid = r_ev_v;
    assign o_rng_a    = r_rng_a;
    assign o_rng_b    = r_rng_b;
    assign o_glb_a    = r_glb_a;
    assign o_glb_b    = r_glb_b;
    assign o_pair     = r_pair;

`ifndef SYNTH
    a_clear_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in_last |=>
            r_min_rng[0] == NO_RETURN && r_min_rng[1] == NO_RETURN &&
            r_min_rng[2] == NO_RETURN && r_min_rng[3] == NO_RETURN)
        else $error("sector minima not cleared after end of scan");

    a_index_in_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW+1)'(r_min_idx[0]) < (LW+1)'(SECTOR_SAMPLES) &&
        (LW+1)'(r_min_idx[1]) < (LW+1)'(SECTOR_SAMPLES) &&
        (LW+1)'(r_min_idx[2]) < (LW+1)'(SECTOR_SAMPLES) &&
        (LW+1)'(r_min_idx[3]) < (LW+1)'(SECTOR_SAMPLES))
        else $error("sector minimum index outside its sector");

    a_pair_positions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_v |->
            ((r_pair == PAIR_B) ?
                (r_glb_a >= GW'(3 * SECTOR_SAMPLES) && r_glb_b >= GW'(SECTOR_SAMPLES) &&
                 r_glb_b < GW'(2 * SECTOR_SAMPLES)) :
                (r_glb_a < GW'(SECTOR_SAMPLES) && r_glb_b >= GW'(2 * SECTOR_SAMPLES) &&
                 r_glb_b < GW'(3 * SECTOR_SAMPLES))))
        else $error("chosen scan positions do not match the chosen pair");
`endif

endmodule

`default_nettype wire

// ===== sv/lqgm_angle.sv =====
`default_nettype none

module lqgm_angle
    import lqgm_pkg::*;
#(
    parameter int SECTOR_SAMPLES     = 360,
    parameter int SAMPLES_PER_DEGREE = 4,
    localparam int GW = $clog2(4 * SECTOR_SAMPLES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire t_range        i_rng_a,
    input  wire t_range        i_rng_b,
    input  wire logic [GW-1:0] i_glb_a,
    input  wire logic [GW-1:0] i_glb_b,
    input  wire logic          i_pair,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output t_range             o_rng_a,
    output t_range             o_rng_b,
    output logic               o_pair,
    output t_trig              o_cos_a,
    output t_trig              o_sin_a,
    output t_trig              o_cos_b,
    output t_trig              o_sin_b
);

    // Degree = position / SAMPLES_PER_DEGREE through an exact reciprocal multiply.
    localparam int DMAX  = (4 * SECTOR_SAMPLES - 1) / SAMPLES_PER_DEGREE;
    localparam int DW    = $clog2(DMAX + 1);
    localparam int EW    = (DW > ANG_W) ? DW : ANG_W;
    localparam int KMAX  = DMAX / DEG_FULL;
    localparam int SH    = GW + 4;
    localparam int RW    = SH + 1;
    localparam int MW    = GW + RW;
    localparam int RECIP = ((1 << SH) + SAMPLES_PER_DEGREE - 1) / SAMPLES_PER_DEGREE;

    logic          r_deg_v;
    logic [DW-1:0] r_deg_a;
    logic [DW-1:0] r_deg_b;
    t_range        r_deg_rng_a;
    t_range        r_deg_rng_b;
    logic          r_deg_pair;

    logic          r_ang_v;
    t_angle        r_ang_a;
    t_angle        r_ang_b;
    t_range        r_ang_rng_a;
    t_range        r_ang_rng_b;
    logic          r_ang_pair;

    logic          r_trig_v;
    t_trig         r_cos_a;
    t_trig         r_sin_a;
    t_trig         r_cos_b;
    t_trig         r_sin_b;
    t_range        r_trig_rng_a;
    t_range        r_trig_rng_b;
    logic          r_trig_pair;

    logic [MW-1:0] prod_a;
    logic [MW-1:0] prod_b;
    t_angle        n_ang_a;
    t_angle        n_ang_b;
    logic          rdy_deg;
    logic          rdy_ang;
    logic          rdy_trig;

    // Whole degrees reduced modulo 360 by a ladder of constant compares.
    function automatic t_angle wrap_deg(input logic [DW-1:0] deg);
        logic [EW-1:0] deg_e;
        logic [EW-1:0] red;
        deg_e = EW'(deg);
        red   = deg_e;
        for (int k = 1; k <= KMAX; k++) begin
            if (deg_e >= EW'(k * DEG_FULL)) begin
                red = deg_e - EW'(k * DEG_FULL);
            end
        end
        return red[ANG_W-1:0];
    endfunction

    // Folds an angle below 180 degrees onto the 0..90 table.
    function automatic logic [SIN_IDX_W-1:0] fold_half(input t_angle a);
        t_angle f;
        f = (a > t_angle'(DEG_QUARTER)) ? t_angle'(DEG_HALF) - a : a;
        return f[SIN_IDX_W-1:0];
    endfunction

    // |sin| of an angle in 0..359.
    function automatic t_trig abs_sin(input t_angle a);
        t_angle h;
        h = (a >= t_angle'(DEG_HALF)) ? a - t_angle'(DEG_HALF) : a;
        return SIN_Q15[fold_half(h)];
    endfunction

    // |cos| of an angle in 0..359, taken as |sin| of the angle plus 90.
    function automatic t_trig abs_cos(input t_angle a);
        t_angle b;
        t_angle h;
        b = a + t_angle'(DEG_QUARTER);
        priority if (b >= t_angle'(DEG_FULL)) begin
            h = b - t_angle'(DEG_FULL);
        end else if (b >= t_angle'(DEG_HALF)) begin
            h = b - t_angle'(DEG_HALF);
        end else begin
            h = b;
        end
        return SIN_Q15[fold_half(h)];
    endfunction

    assign prod_a  = MW'(i_glb_a) * MW'(RECIP);
    assign prod_b  = MW'(i_glb_b) * MW'(RECIP);
    assign n_ang_a = wrap_deg(r_deg_a);
    assign n_ang_b = wrap_deg(r_deg_b);

    // Each stage moves on when it is empty or the next one takes its item.
    assign rdy_trig   = !r_trig_v || i_out_ready;
    assign rdy_ang    = !r_ang_v || rdy_trig;
    assign rdy_deg    = !r_deg_v || rdy_ang;
    assign o_in_ready = rdy_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_v  <= 1'b0;
            r_ang_v  <= 1'b0;
            r_trig_v <= 1'b0;
        end else begin
            if (rdy_deg) begin
                r_deg_v <= i_in_valid;
            end
            if (rdy_ang) begin
                r_ang_v <= r_deg_v;
            end
            if (rdy_trig) begin
                r_trig_v <= r_ang_v;
            end
        end
    end

    // Degree stage, wrap stage and table stage payloads.
    always_ff @(posedge i_clk) begin
        if (rdy_deg && i_in_valid) begin
            r_deg_a     <= prod_a[SH +: DW];
            r_deg_b     <= prod_b[SH +: DW];
            r_deg_rng_a <= i_rng_a;
            r_deg_rng_b <= i_rng_b;
            r_deg_pair  <= i_pair;
        end
        if (rdy_ang && r_deg_v) begin
            r_ang_a     <= n_ang_a;
            r_ang_b     <= n_ang_b;
            r_ang_rng_a <= r_deg_rng_a;
            r_ang_rng_b <= r_deg_rng_b;
            r_ang_pair  <= r_deg_pair;
        end
        if (rdy_trig && r_ang_v) begin
            r_cos_a      <= abs_cos(r_ang_a);
            r_sin_a      <= abs_sin(r_ang_a);
            r_cos_b      <= abs_cos(r_ang_b);
            r_sin_b      <= abs_sin(r_ang_b);
            r_trig_rng_a <= r_ang_rng_a;
            r_trig_rng_b <= r_ang_rng_b;
            r_trig_pair  <= r_ang_pair;
        end
    end

    assign o_out_valid = r_trig_v;
    assign o_rng_a     = r_trig_rng_a;
    assign o_rng_b     = r_trig_rng_b;
    assign o_pair      = r_trig_pair;
    assign o_cos_a     = r_cos_a;
    assign o_sin_a     = r_sin_a;
    assign o_cos_b     = r_cos_b;
    assign o_sin_b     = r_sin_b;

endmodule

`default_nettype wire

// ===== sv/lqgm_point.sv =====
`default_nettype none

module lqgm_point
    import lqgm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_range i_rng_a,
    input  wire t_range i_rng_b,
    input  wire logic  i_pair,
    input  wire t_trig i_cos_a,
    input  wire t_trig i_sin_a,
    input  wire t_trig i_cos_b,
    input  wire t_trig i_sin_b,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_coord     o_mid_x_mm,
    output t_coord     o_mid_y_mm,
    output logic       o_pair_used
);

    logic       r_prod_v;
    t_prod      r_px_a;
    t_prod      r_py_a;
    t_prod      r_px_b;
    t_prod      r_py_b;
    logic       r_prod_pair;

    logic       r_sum_v;
    t_sum       r_sum_x;
    t_sum       r_sum_y;
    logic       r_sum_pair;

    logic       r_out_v;
    t_coord     r_mid_x;
    t_coord     r_mid_y;
    logic       r_out_pair;

    logic [1:0] sec_a;
    logic [1:0] sec_b;
    t_sum       n_sum_x;
    t_sum       n_sum_y;
    logic       rdy_prod;
    logic       rdy_sum;
    logic       rdy_out;

    // Widens a product and applies its quadrant sign.
    function automatic t_sum signed_term(input t_prod p, input logic neg);
        t_sum v;
        v = t_sum'({1'b0, p});
        return neg ? -v : v;
    endfunction

    // Halves the Q15 sum, rounds half away from zero and saturates.
    function automatic t_coord finish(input t_sum sum);
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] rnd;
        logic [OUT_W-1:0] q;
        neg = sum[SUM_W-1];
        mag = neg ? SUM_W'(-sum) : SUM_W'(sum);
        rnd = mag + ROUND_HALF;
        q   = rnd[SUM_W-1:FRAC_SH];
        if (q > OUT_MAX) begin
            q = OUT_MAX;
        end
        return neg ? -t_coord'(q) : t_coord'(q);
    endfunction

    // Sectors of the pair held in the product stage.
    assign sec_a   = (r_prod_pair == PAIR_B) ? SEC3 : SEC0;
    assign sec_b   = (r_prod_pair == PAIR_B) ? SEC1 : SEC2;
    assign n_sum_x = signed_term(r_px_a, NEG_X[sec_a]) + signed_term(r_px_b, NEG_X[sec_b]);
    assign n_sum_y = signed_term(r_py_a, NEG_Y[sec_a]) + signed_term(r_py_b, NEG_Y[sec_b]);

    assign rdy_out    = !r_out_v || i_ready;
    assign rdy_sum    = !r_sum_v || rdy_out;
    assign rdy_prod   = !r_prod_v || rdy_sum;
    assign o_in_ready = rdy_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_sum_v  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (rdy_prod) begin
                r_prod_v <= i_in_valid;
            end
            if (rdy_sum) begin
                r_sum_v <= r_prod_v;
            end
            if (rdy_out) begin
                r_out_v <= r_sum_v;
            end
        end
    end

    // Product stage, sum stage and result register payloads.
    always_ff @(posedge i_clk) begin
        if (rdy_prod && i_in_valid) begin
            r_px_a      <= PROD_W'(i_rng_a) * PROD_W'(i_cos_a);
            r_py_a      <= PROD_W'(i_rng_a) * PROD_W'(i_sin_a);
            r_px_b      <= PROD_W'(i_rng_b) * PROD_W'(i_cos_b);
            r_py_b      <= PROD_W'(i_rng_b) * PROD_W'(i_sin_b);
            r_prod_pair <= i_pair;
        end
        if (rdy_sum && r_prod_v) begin
            r_sum_x    <= n_sum_x;
            r_sum_y    <= n_sum_y;
            r_sum_pair <= r_prod_pair;
        end
        if (rdy_out && r_sum_v) begin
            r_mid_x    <= finish(r_sum_x);
            r_mid_y    <= finish(r_sum_y);
            r_out_pair <= r_sum_pair;
        end
    end

    assign o_valid     = r_out_v;
    assign o_mid_x_mm  = r_mid_x;
    assign o_mid_y_mm  = r_mid_y;
    assign o_pair_used = r_out_pair;

endmodule

`default_nettype wire

// ===== sv/lidar_quadrant_gap_midpoint_core.sv =====
// Results: a sample that ends a scan and gets a pair passes through the input, pair,
// degree, wrap, table, product, sum and result registers; other samples give none.
// Throughput: one sample per cycle if not stalled, set by the single compare per sample
// on the sector minima; later stages hold only end-of-scan items and close up bubbles.
// Reset: synchronous, active low; clears all stage valid bits and sets every sector
// minimum to no return at index zero.
`default_nettype none

module lidar_quadrant_gap_midpoint_core
    import lqgm_pkg::*;
#(
    parameter int SECTOR_SAMPLES     = 360,
    parameter int SAMPLES_PER_DEGREE = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [RNG_W-1:0]    i_range_mm,
    input  wire logic [IDX_IN_W-1:0] i_sample_index,
    input  wire logic                i_end_of_scan,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [OUT_W-1:0]  o_mid_x_mm,
    output logic signed [OUT_W-1:0]  o_mid_y_mm,
    output logic                     o_pair_used
);

    localparam int GW = $clog2(4 * SECTOR_SAMPLES);

    logic          ev_valid;
    logic          ev_ready;
    t_range        ev_rng_a;
    t_range        ev_rng_b;
    logic [GW-1:0] ev_glb_a;
    logic [GW-1:0] ev_glb_b;
    logic          ev_pair;

    logic          tr_valid;
    logic          tr_ready;
    t_range        tr_rng_a;
    t_range        tr_rng_b;
    logic          tr_pair;
    t_trig         tr_cos_a;
    t_trig         tr_sin_a;
    t_trig         tr_cos_b;
    t_trig         tr_sin_b;

    // Input register, sector minima and pair choice.
    lqgm_sector #(
        .SECTOR_SAMPLES (SECTOR_SAMPLES)
    ) u_sector (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_range_mm     (i_range_mm),
        .i_sample_index (i_sample_index),
        .i_end_of_scan  (i_end_of_scan),
        .o_ev_valid     (ev_valid),
        .i_ev_ready     (ev_ready),
        .o_rng_a        (ev_rng_a),
        .o_rng_b        (ev_rng_b),
        .o_glb_a        (ev_glb_a),
        .o_glb_b        (ev_glb_b),
        .o_pair         (ev_pair)
    );

    // Angle of each chosen minimum and its trig magnitudes.
    lqgm_angle #(
        .SECTOR_SAMPLES     (SECTOR_SAMPLES),
        .SAMPLES_PER_DEGREE (SAMPLES_PER_DEGREE)
    ) u_angle (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (ev_valid),
        .o_in_ready  (ev_ready),
        .i_rng_a     (ev_rng_a),
        .i_rng_b     (ev_rng_b),
        .i_glb_a     (ev_glb_a),
        .i_glb_b     (ev_glb_b),
        .i_pair      (ev_pair),
        .o_out_valid (tr_valid),
        .i_out_ready (tr_ready),
        .o_rng_a     (tr_rng_a),
        .o_rng_b     (tr_rng_b),
        .o_pair      (tr_pair),
        .o_cos_a     (tr_cos_a),
        .o_sin_a     (tr_sin_a),
        .o_cos_b     (tr_cos_b),
        .o_sin_b     (tr_sin_b)
    );

    // Coordinates, midpoint and result register.
    lqgm_point u_point (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (tr_valid),
        .o_in_ready  (tr_ready),
        .i_rng_a     (tr_rng_a),
        .i_rng_b     (tr_rng_b),
        .i_pair      (tr_pair),
        .i_cos_a     (tr_cos_a),
        .i_sin_a     (tr_sin_a),
        .i_cos_b     (tr_cos_b),
        .i_sin_b     (tr_sin_b),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_mid_x_mm  (o_mid_x_mm),
        .o_mid_y_mm  (o_mid_y_mm),
        .o_pair_used (o_pair_used)
    );

endmodule

`default_nettype wire

// ===== tb/tb_lidar_quadrant_gap_midpoint_core.sv =====
`default_nettype none

module tb_lidar_quadrant_gap_midpoint_core;
    import lqgm_pkg::*;

    localparam int SECTOR_SAMPLES     = 360;
    localparam int SAMPLES_PER_DEGREE = 4;
    localparam int SECTORS            = 4;
    localparam int SCAN_SAMPLES       = SECTORS * SECTOR_SAMPLES;
    localparam int INDEX_MAX          = (1 << IDX_IN_W) - 1;
    localparam int RANDOM_SAMPLES     = 500;
    localparam int CYCLE_LIMIT        = 200000;
    localparam int DRAIN_CYCLES       = 20;
    localparam int MAX_REPORTS        = 10;
    localparam int DIR_COUNT          = 25;

    typedef logic [IDX_IN_W-1:0] t_index;
    typedef logic [8:0]          t_local;

    typedef enum logic {CHK_MODEL, CHK_TYPED} t_check;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_EVERY4, RDY_SPARSE} t_stall;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   pair;
    } t_midpoint;

    typedef struct packed {
        t_range    rng;
        t_index    idx;
        logic      eos;
        t_check    check;
        logic      has_mid;
        t_midpoint mid;
    } t_dir_row;

    // Directed samples. Typed rows carry their own expected midpoint (or none).
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        // End of scan on an ignored index right after reset: every sector is empty.
        '{16'd0,     11'd2047, 1'b1, CHK_TYPED, 1'b1, '{17'sd0, 17'sd0, PAIR_A}},
        '{16'd0,     11'd0,    1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd65535, 11'd1439, 1'b0, CHK_MODEL, 1'b0, '0},
        // Sector one empty, sector zero at zero range: only sector two counts.
        '{16'd0,     11'd1440, 1'b1, CHK_TYPED, 1'b1, '{17'sd32768, 17'sd0, PAIR_A}},
        // Tie in sector one, lower index arrives second; sector two empty.
        '{16'd1000,  11'd400,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd1000,  11'd380,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd2000,  11'd1100, 1'b1, CHK_MODEL, 1'b0, '0},
        // Tie in sector two, lower index arrives first; sector zero nearer.
        '{16'd5,     11'd721,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd5,     11'd1000, 1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd7,     11'd360,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd3,     11'd359,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd9,     11'd1439, 1'b1, CHK_MODEL, 1'b0, '0},
        // Sector three nearer than sector zero.
        '{16'd50,    11'd10,   1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd20,    11'd700,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd20,    11'd1079, 1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd40,    11'd1080, 1'b1, CHK_MODEL, 1'b0, '0},
        // Equal minima in sectors zero and three: no midpoint.
        '{16'd100,   11'd100,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd200,   11'd500,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd300,   11'd800,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd100,   11'd1200, 1'b1, CHK_TYPED, 1'b0, '0},
        // Near full-scale ranges at the last index of each sector.
        '{16'd65534, 11'd359,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd65534, 11'd719,  1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd65534, 11'd1079, 1'b0, CHK_MODEL, 1'b0, '0},
        '{16'd65533, 11'd1439, 1'b1, CHK_MODEL, 1'b0, '0},
        // A no-return sample ends a scan: same as an empty scan.
        '{16'd65535, 11'd719,  1'b1, CHK_TYPED, 1'b1, '{17'sd0, 17'sd0, PAIR_A}}
    };

    logic   i_clk          = 1'b0;
    logic   i_rst_n        = 1'b0;
    logic   i_valid        = 1'b0;
    logic   o_ready;
    t_range i_range_mm     = '0;
    t_index i_sample_index = '0;
    logic   i_end_of_scan  = 1'b0;
    logic   o_valid;
    logic   i_ready        = 1'b0;
    t_coord o_mid_x_mm;
    t_coord o_mid_y_mm;
    logic   o_pair_used;

    // Nearest return per sector as the testbench sees it.
    t_range    near_rng [SECTORS];
    t_local    near_idx [SECTORS];
    t_midpoint mid_queue [$];

    int     fail_count  = 0;
    int     cycle_count = 0;
    int     burst_left  = 0;
    t_stall stall_mode  = RDY_ALWAYS;

    lidar_quadrant_gap_midpoint_core #(
        .SECTOR_SAMPLES     (SECTOR_SAMPLES),
        .SAMPLES_PER_DEGREE (SAMPLES_PER_DEGREE)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_range_mm     (i_range_mm),
        .i_sample_index (i_sample_index),
        .i_end_of_scan  (i_end_of_scan),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mid_x_mm     (o_mid_x_mm),
        .o_mid_y_mm     (o_mid_y_mm),
        .o_pair_used    (o_pair_used)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic void clear_nearest();
        for (int s = 0; s < SECTORS; s++) begin
            near_rng[s] = NO_RETURN;
            near_idx[s] = '0;
        end
    endfunction

    // Magnitude of the sine of a whole degree, in Q15.
    function automatic longint q15_sin_mag(int unsigned deg);
        int unsigned a;
        a = deg % DEG_HALF;
        if (a > DEG_QUARTER) begin
            a = DEG_HALF - a;
        end
        return longint'(SIN_Q15[a]);
    endfunction

    // Signed x and y products (range times Q15) of one sector's nearest return.
    function automatic void sector_products(int s, output longint px, output longint py);
        int unsigned deg;
        longint      r;
        deg = ((s * SECTOR_SAMPLES + near_idx[s]) / SAMPLES_PER_DEGREE) % DEG_FULL;
        r   = longint'(near_rng[s]);
        px  = r * q15_sin_mag(deg + DEG_QUARTER);
        py  = r * q15_sin_mag(deg);
        if (NEG_X[s]) begin
            px = -px;
        end
        if (NEG_Y[s]) begin
            py = -py;
        end
    endfunction

    // Halves the Q15 sum, rounds half away from zero and saturates.
    function automatic t_coord halve_round_sat(longint sum);
        longint mag;
        mag = (sum < 0) ? -sum : sum;
        mag = (mag + longint'(ROUND_HALF)) >>> FRAC_SH;
        if (mag > longint'(OUT_MAX)) begin
            mag = longint'(OUT_MAX);
        end
        return t_coord'((sum < 0) ? -mag : mag);
    endfunction

    // Folds one accepted sample into the sector minima. On end of scan it picks the
    // sector pair, builds the midpoint if there is one, and clears the minima.
    function automatic bit track_sample(t_range rng, t_index idx, logic eos,
                                        output t_midpoint mid);
        int     s;
        t_local loc;
        int     a;
        int     b;
        longint ax;
        longint ay;
        longint bx;
        longint by;
        logic   pair;
        bit     emit;
        mid  = '0;
        pair = PAIR_A;
        emit = 1'b1;
        if (idx < SCAN_SAMPLES) begin
            s   = idx / SECTOR_SAMPLES;
            loc = t_local'(idx % SECTOR_SAMPLES);
            if (rng < near_rng[s] || (rng == near_rng[s] && loc < near_idx[s])) begin
                near_rng[s] = rng;
                near_idx[s] = loc;
            end
        end
        if (!eos) begin
            return 1'b0;
        end
        if (near_rng[SEC1] == NO_RETURN) begin
            pair = PAIR_A;
        end else if (near_rng[SEC2] == NO_RETURN) begin
            pair = PAIR_B;
        end else if (near_rng[SEC0] < near_rng[SEC3]) begin
            pair = PAIR_A;
        end else if (near_rng[SEC0] > near_rng[SEC3]) begin
            pair = PAIR_B;
        end else begin
            emit = 1'b0;
        end
        if (emit) begin
            a = (pair == PAIR_A) ? SEC0 : SEC3;
            b = (pair == PAIR_A) ? SEC2 : SEC1;
            sector_products(a, ax, ay);
            sector_products(b, bx, by);
            mid.x    = halve_round_sat(ax + bx);
            mid.y    = halve_round_sat(ay + by);
            mid.pair = pair;
        end
        clear_nearest();
        return emit;
    endfunction

    // Ranges lean toward the edges and a tiny set, so that ties and equal minima occur.
    function automatic t_range draw_range_mm();
        case ($urandom_range(0, 7))
            0: return NO_RETURN;
            1: return '0;
            2: return t_range'(100 + $urandom_range(0, 1));
            3: return t_range'($urandom_range(60000, 65535));
            4, 5: return t_range'($urandom_range(0, 4000));
            default: return t_range'($urandom_range(0, 65535));
        endcase
    endfunction

    // A sample index inside the scan, often at a sector border.
    function automatic t_index draw_scan_index();
        int s;
        int loc;
        s = $urandom_range(0, SECTORS - 1);
        case ($urandom_range(0, 3))
            0: loc = 0;
            1: loc = SECTOR_SAMPLES - 1;
            default: loc = $urandom_range(0, SECTOR_SAMPLES - 1);
        endcase
        return t_index'(s * SECTOR_SAMPLES + loc);
    endfunction

    // Sends one item in bursts with idle gaps, then records what it should produce.
    task automatic send_sample(input t_dir_row row);
        t_midpoint mid;
        bit        emit;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid        <= 1'b1;
        i_range_mm     <= row.rng;
        i_sample_index <= row.idx;
        i_end_of_scan  <= row.eos;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        emit = track_sample(row.rng, row.idx, row.eos, mid);
        if (row.check == CHK_TYPED) begin
            if (row.has_mid) begin
                mid_queue.push_back(row.mid);
            end
        end else if (emit) begin
            mid_queue.push_back(mid);
        end
    endtask

    // Holds the sender off until every pending midpoint has come out.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (mid_queue.size() != 0);
    endtask

    // Result check and receiver stall pattern.
    always @(posedge i_clk) begin : result_check
        t_midpoint want;
        cycle_count++;
        if (i_rst_n && o_valid && i_ready) begin
            if (mid_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected midpoint: x=%0d y=%0d pair=%0b",
                             o_mid_x_mm, o_mid_y_mm, o_pair_used);
                end
            end else begin
                want = mid_queue.pop_front();
                if (o_mid_x_mm !== want.x || o_mid_y_mm !== want.y
                        || o_pair_used !== want.pair) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("midpoint mismatch: expected x=%0d y=%0d pair=%0b, got x=%0d y=%0d pair=%0b",
                                 want.x, want.y, want.pair,
                                 o_mid_x_mm, o_mid_y_mm, o_pair_used);
                    end
                end
            end
        end
        // The stall style is redrawn periodically from the four patterns.
        if (cycle_count % 97 == 0) begin
            stall_mode = t_stall'($urandom_range(0, 3));
        end
        case (stall_mode)
            RDY_ALWAYS: i_ready <= 1'b1;
            RDY_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RDY_EVERY4: i_ready <= (cycle_count % 4 == 0);
            default:    i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog on the cycle count.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_dir_row row;
        int       counted;
        int       scan_len;
        bit       paused;
        counted = 0;
        paused  = 1'b0;
        clear_nearest();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        for (int n = 0; n < DIR_COUNT; n++) begin
            send_sample(DIR_ROWS[n]);
        end

        // Random scans: mostly short well-formed scans, with some long ones and
        // samples beyond the last sector mixed in.
        while (counted < RANDOM_SAMPLES) begin
            scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
            for (int k = 0; k < scan_len; k++) begin
                row       = '0;
                row.check = CHK_MODEL;
                row.rng   = draw_range_mm();
                if ($urandom_range(0, 11) == 0) begin
                    row.idx = t_index'($urandom_range(SCAN_SAMPLES, INDEX_MAX));
                end else begin
                    row.idx = draw_scan_index();
                    counted++;
                end
                row.eos = (k == scan_len - 1);
                send_sample(row);
            end
            if (!paused && counted >= RANDOM_SAMPLES / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end

        // Let the last midpoints drain, then allow for the pipeline depth.
        i_valid <= 1'b0;
        while (mid_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
